// ===== rtl/gas_pkg.sv =====
// gas_pkg: shared types and constants for the gravity acceleration sum core.
// Used by the controller, the datapath and the top level.
package gas_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic CSR_BODY_COUNT = 1'b0;
   localparam logic CSR_MIN_DIST   = 1'b1;

   localparam logic [7:0]  MIN_DIST_RESET = 8'd40;
   localparam logic [32:0] G_CAP          = 33'h1_FFFF_FFFF;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_WRITE,
      OP_LOAD,
      OP_READ,
      OP_DIFF,
      OP_SQX,
      OP_SQY,
      OP_SUM,
      OP_SQRT,
      OP_DIV_T,
      OP_DIV_G,
      OP_DIV_U,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_TERM,
      OP_ACC,
      OP_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      axis;   // 0: x, 1: y
   } dp_cmd_type;

   typedef struct packed {
      logic skip;        // body x equals query x
      logic in_range;    // squared distance beyond cutoff
      logic busy;        // root or divider running
   } dp_status_type;

endpackage

// ===== rtl/gravity_accel_sum_core.sv =====
// gravity_accel_sum_core: top level of the direct-sum 2D gravity acceleration block.
// Depends on gas_pkg, gas_ctrl and gas_dp.
//
// Usage:
//   req channel (tvalid/tready/tdata/tuser): tuser = command (0 write body,
//   1 query). A write stores x, y and mass at body_index and returns nothing.
//   A query returns one rsp transaction with the velocity passed through and
//   the saturating Q16.16 acceleration sum over the first body_count entries.
//   csr port: csr_we with csr_addr 0 = body_count, 1 = min_distance; the user
//   writes these only while the block is idle; the block itself does not enforce this.
// Sequencing:
//   A write is taken in the idle state. A query holds the block from accept
//   to finish; per body it reads the entry, skips it when its x equals the
//   query x, stops after the cutoff test when it lies inside the cutoff, and
//   otherwise runs the root and divides; rsp_tvalid is set from the finish
//   state once the output register is free. The per-body time is set by the
//   shared root unit (33 steps) and the shared one-bit-per-cycle divider,
//   used four times (64 steps each). One transaction is worked on at a time.
// Reset: synchronous; body_count clears to 0, min_distance to 40. The body
//   tables are not cleared; entries read before being written are undefined.
// Stall: the result sits in an output register; a new transaction is taken
//   while it waits, and a finished query holds until the register is free.
module gravity_accel_sum_core
   import gas_pkg::*;
#(
   parameter int MAX_BODIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [5:0] body_index, [37:6] pos_x, [69:38] pos_y, [101:70] vel_x,
   // [133:102] vel_y, [165:134] body_mass, [167:166] zero
   input  logic [167:0] req_tdata,
   // [0] command
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] rate_x, [63:32] rate_y, [95:64] accel_x, [127:96] accel_y
   output logic [127:0] rsp_tdata,
   // [0] saturated
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rate_x, rate_y, accel_x, accel_y;
   logic          saturated;

   gas_ctrl #(.MAX_BODIES(MAX_BODIES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_count   (csr_wdata[6:0]),
      .status      (status),
      .cmd         (cmd),
      .rd_addr     (rd_addr)
   );

   gas_dp #(.MAX_BODIES(MAX_BODIES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .body_index (req_tdata[5:0]),
      .pos_x      (req_tdata[37:6]),
      .pos_y      (req_tdata[69:38]),
      .vel_x      (req_tdata[101:70]),
      .vel_y      (req_tdata[133:102]),
      .body_mass  (req_tdata[165:134]),
      .status     (status),
      .rate_x     (rate_x),
      .rate_y     (rate_y),
      .accel_x    (accel_x),
      .accel_y    (accel_y),
      .saturated  (saturated)
   );

   assign rsp_tdata = {accel_y, accel_x, rate_y, rate_x};
   assign rsp_tuser = saturated;

endmodule

// ===== rtl/gas_div.sv =====
// gas_div: restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
// Depends on nothing.
module gas_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);

   logic [63:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dsr_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [33:0] rem_t, diff;
   logic        ge;

   always_comb begin
      rem_t  = {rem_ff, dvd_ff[63]};
      diff   = rem_t - {1'b0, dsr_ff};
      ge     = rem_t >= {1'b0, dsr_ff};
      rem_in = ge ? diff[32:0] : rem_t[32:0];
      dvd_in = {dvd_ff[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/gas_sqrt.sv =====
// gas_sqrt: digit-by-digit integer square root of a 65-bit value, one root bit per cycle.
// Depends on nothing.
module gas_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [64:0] radicand,
   output logic        busy,
   output logic [32:0] root
);

   logic [65:0] rad_ff;
   logic [34:0] rem_ff, rem_in;
   logic [32:0] root_ff, root_in;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [36:0] rem_t, trial;

   always_comb begin
      rem_t = {rem_ff, rad_ff[65:64]};
      trial = {2'b00, root_ff, 2'b01};
      if (rem_t >= trial) begin
         rem_in  = 35'(rem_t - trial);
         root_in = {root_ff[31:0], 1'b1};
      end else begin
         rem_in  = rem_t[34:0];
         root_in = {root_ff[31:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'd32) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {1'b0, radicand};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[63:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== rtl/gas_dp.sv =====
// gas_dp: body tables, per-body arithmetic, accumulators and result registers.
// Depends on gas_pkg, gas_sqrt and gas_div.
module gas_dp
   import gas_pkg::*;
#(
   parameter int MAX_BODIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] rd_addr,
   input  logic                csr_we,
   input  logic                csr_addr,
   input  logic [15:0]         csr_wdata,
   input  logic [5:0]          body_index,
   input  logic [31:0]         pos_x,
   input  logic [31:0]         pos_y,
   input  logic [31:0]         vel_x,
   input  logic [31:0]         vel_y,
   input  logic [31:0]         body_mass,
   output dp_status_type       status,
   output logic [31:0]         rate_x,
   output logic [31:0]         rate_y,
   output logic [31:0]         accel_x,
   output logic [31:0]         accel_y,
   output logic                saturated
);

   localparam int AW   = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int IW   = (AW > 6) ? AW : 6;
   localparam int CMPW = (IW > 11) ? IW + 1 : 12;
   localparam int ACCW = 35 + $clog2(MAX_BODIES + 1);

   logic [31:0] mem_x [MAX_BODIES];
   logic [31:0] mem_y [MAX_BODIES];
   logic [31:0] mem_m [MAX_BODIES];

   logic [15:0] min_dist_ff;
   logic [31:0] qx_ff, qy_ff, vx_ff, vy_ff;
   logic [31:0] bx_ff, by_ff, bm_ff;
   logic [31:0] mx_ff, my_ff;
   logic        negx_ff, negy_ff;
   logic [63:0] sx_ff, sy_ff, cut2_ff;
   logic [64:0] s_ff;
   logic [32:0] g_ff;
   logic [47:0] pl_ff;
   logic [46:0] ph_ff;
   logic [33:0] c_ff;
   logic signed [ACCW-1:0] ax_ff, ay_ff;
   logic        sat_ff;
   logic [31:0] rx_ff, ry_ff, accx_ff, accy_ff;
   logic        rsat_ff;

   logic [IW-1:0] idx_w;
   logic          wr_ok;
   logic [32:0]   dx, dy, adx, ady;
   logic [31:0]   sq_a;
   logic [63:0]   sq_p;
   logic [30:0]   u_val;
   logic [64:0]   term_sum;
   logic          sq_start, dv_start, sq_busy, dv_busy;
   logic [32:0]   root;
   logic [63:0]   quot;
   logic [63:0]   dv_dividend;
   logic          ovx, ovy;
   logic [31:0]   clx, cly;

   assign idx_w = IW'(body_index);
   assign wr_ok = CMPW'(body_index) < CMPW'(MAX_BODIES);

   assign dx  = {qx_ff[31], qx_ff} - {bx_ff[31], bx_ff};
   assign dy  = {qy_ff[31], qy_ff} - {by_ff[31], by_ff};
   assign adx = dx[32] ? -dx : dx;
   assign ady = dy[32] ? -dy : dy;

   assign sq_a     = (cmd.op == OP_SQX) ? mx_ff : my_ff;
   assign sq_p     = sq_a * sq_a;
   assign u_val    = quot[30:0];
   assign term_sum = {1'b0, ph_ff, 17'b0} + {17'b0, pl_ff};

   assign sq_start = cmd.op == OP_SQRT;
   assign dv_start = (cmd.op == OP_DIV_T) || (cmd.op == OP_DIV_G) || (cmd.op == OP_DIV_U);

   always_comb begin
      case (cmd.op)
         OP_DIV_T: dv_dividend = {16'b0, bm_ff, 16'b0};
         OP_DIV_G: dv_dividend = {quot[47:0], 16'b0};
         default:  dv_dividend = {2'b0, (cmd.axis ? my_ff : mx_ff), 30'b0};
      endcase
   end

   // saturate the wide sums to 32 bits
   assign ovx = !((&ax_ff[ACCW-1:31]) || !(|ax_ff[ACCW-1:31]));
   assign ovy = !((&ay_ff[ACCW-1:31]) || !(|ay_ff[ACCW-1:31]));
   assign clx = ovx ? (ax_ff[ACCW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ax_ff[31:0];
   assign cly = ovy ? (ay_ff[ACCW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ay_ff[31:0];

   gas_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (s_ff),
      .busy     (sq_busy),
      .root     (root)
   );

   gas_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (root),
      .busy     (dv_busy),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= {8'b0, MIN_DIST_RESET};
      end else if (csr_we && csr_addr == CSR_MIN_DIST) begin
         min_dist_ff <= csr_wdata;
      end
   end

   // body tables
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE && wr_ok) begin
         mem_x[idx_w[AW-1:0]] <= pos_x;
         mem_y[idx_w[AW-1:0]] <= pos_y;
         mem_m[idx_w[AW-1:0]] <= body_mass;
      end
      if (cmd.op == OP_READ) begin
         bx_ff <= mem_x[rd_addr];
         by_ff <= mem_y[rd_addr];
         bm_ff <= mem_m[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            qx_ff   <= pos_x;
            qy_ff   <= pos_y;
            vx_ff   <= vel_x;
            vy_ff   <= vel_y;
            ax_ff   <= '0;
            ay_ff   <= '0;
            sat_ff  <= 1'b0;
            cut2_ff <= {32'(min_dist_ff * min_dist_ff), 32'b0};
         end
         OP_DIFF: begin
            mx_ff   <= adx[31:0];
            my_ff   <= ady[31:0];
            negx_ff <= dx[32];
            negy_ff <= dy[32];
         end
         OP_SQX:    sx_ff <= sq_p;
         OP_SQY:    sy_ff <= sq_p;
         OP_SUM:    s_ff  <= {1'b0, sx_ff} + {1'b0, sy_ff};
         OP_DIV_U: begin
            if (!cmd.axis) begin
               if (quot > 64'(G_CAP)) begin
                  g_ff   <= G_CAP;
                  sat_ff <= 1'b1;
               end else begin
                  g_ff <= quot[32:0];
               end
            end
         end
         OP_MUL_LO: pl_ff <= g_ff[16:0] * u_val;
         OP_MUL_HI: ph_ff <= g_ff[32:17] * u_val;
         OP_TERM:   c_ff  <= term_sum[63:30];
         OP_ACC: begin
            if (!cmd.axis) begin
               ax_ff <= negx_ff ? ax_ff + ACCW'(c_ff) : ax_ff - ACCW'(c_ff);
            end else begin
               ay_ff <= negy_ff ? ay_ff + ACCW'(c_ff) : ay_ff - ACCW'(c_ff);
            end
         end
         OP_FIN: begin
            rx_ff   <= vx_ff;
            ry_ff   <= vy_ff;
            accx_ff <= clx;
            accy_ff <= cly;
            rsat_ff <= sat_ff | ovx | ovy;
         end
         default: ;
      endcase
   end

   assign status.skip     = bx_ff == qx_ff;
   assign status.in_range = s_ff > {1'b0, cut2_ff};
   assign status.busy     = sq_busy | dv_busy;

   assign rate_x    = rx_ff;
   assign rate_y    = ry_ff;
   assign accel_x   = accx_ff;
   assign accel_y   = accy_ff;
   assign saturated = rsat_ff;

`ifndef SYNTH
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sq_busy && dv_busy))
      else $error("root and divider running together");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (sq_start || dv_start) |-> !(sq_busy || dv_busy))
      else $error("unit started while busy");
`endif

endmodule

// ===== rtl/gas_ctrl.sv =====
// gas_ctrl: sequencer for writes and queries, body counter and result valid flag.
// Depends on gas_pkg.
module gas_ctrl
   import gas_pkg::*;
#(
   parameter int MAX_BODIES = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_command,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_we,
   input  logic          csr_addr,
   input  logic [6:0]    csr_count,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic [((MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1)-1:0] rd_addr
);

   localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CW = (AW + 1 > $clog2(MAX_BODIES + 1)) ? AW + 1 : $clog2(MAX_BODIES + 1);
   localparam int LW = (CW > 7) ? CW + 1 : 8;

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_DIFF, S_SQX, S_SQY, S_SUM, S_CUT,
      S_SQRT, S_SQRT_W, S_DIVT, S_DIVT_W, S_DIVG, S_DIVG_W,
      S_DIVU, S_DIVU_W, S_MLO, S_MHI, S_TERM, S_ACC, S_NEXT, S_FIN
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] cnt_ff;
   logic          axis_ff;
   logic          valid_ff;
   logic [6:0]    bc_ff;
   logic [LW-1:0] lim;
   logic          last;
   logic          out_free;

   assign lim = (LW'(bc_ff) > LW'(MAX_BODIES)) ? LW'(MAX_BODIES) : LW'(bc_ff);
   assign last     = (LW'(cnt_ff) + LW'(1)) >= lim;
   assign out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
         valid_ff <= 1'b0;
         bc_ff    <= '0;
      end else begin
         if (csr_we && csr_addr == CSR_BODY_COUNT) bc_ff <= csr_count;
         if (valid_ff && rsp_tready) valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_tvalid && req_command == CMD_QUERY) begin
                  state_ff <= (lim == '0) ? S_FIN : S_READ;
               end
            end
            S_READ:   state_ff <= S_DIFF;
            S_DIFF:   state_ff <= status.skip ? S_NEXT : S_SQX;
            S_SQX:    state_ff <= S_SQY;
            S_SQY:    state_ff <= S_SUM;
            S_SUM:    state_ff <= S_CUT;
            S_CUT:    state_ff <= status.in_range ? S_SQRT : S_NEXT;
            S_SQRT:   state_ff <= S_SQRT_W;
            S_SQRT_W: if (!status.busy) state_ff <= S_DIVT;
            S_DIVT:   state_ff <= S_DIVT_W;
            S_DIVT_W: if (!status.busy) state_ff <= S_DIVG;
            S_DIVG:   state_ff <= S_DIVG_W;
            S_DIVG_W: begin
               axis_ff <= 1'b0;
               if (!status.busy) state_ff <= S_DIVU;
            end
            S_DIVU:   state_ff <= S_DIVU_W;
            S_DIVU_W: if (!status.busy) state_ff <= S_MLO;
            S_MLO:    state_ff <= S_MHI;
            S_MHI:    state_ff <= S_TERM;
            S_TERM:   state_ff <= S_ACC;
            S_ACC: begin
               axis_ff  <= 1'b1;
               state_ff <= axis_ff ? S_NEXT : S_DIVU;
            end
            S_NEXT: begin
               cnt_ff   <= cnt_ff + CW'(1);
               state_ff <= last ? S_FIN : S_READ;
            end
            S_FIN: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE:  cmd.op = !req_tvalid ? OP_NONE :
                           (req_command == CMD_QUERY) ? OP_LOAD : OP_WRITE;
         S_READ:  cmd.op = OP_READ;
         S_DIFF:  cmd.op = OP_DIFF;
         S_SQX:   cmd.op = OP_SQX;
         S_SQY:   cmd.op = OP_SQY;
         S_SUM:   cmd.op = OP_SUM;
         S_SQRT:  cmd.op = OP_SQRT;
         S_DIVT:  cmd.op = OP_DIV_T;
         S_DIVG:  cmd.op = OP_DIV_G;
         S_DIVU:  cmd.op = OP_DIV_U;
         S_MLO:   cmd.op = OP_MUL_LO;
         S_MHI:   cmd.op = OP_MUL_HI;
         S_TERM:  cmd.op = OP_TERM;
         S_ACC:   cmd.op = OP_ACC;
         S_FIN:   cmd.op = out_free ? OP_FIN : OP_NONE;
         default: cmd.op = OP_NONE;
      endcase
   end

   assign rd_addr    = cnt_ff[AW-1:0];
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = valid_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      LW'(cnt_ff) <= LW'(MAX_BODIES))
      else $error("body counter past table");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result raised outside finish");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_command == CMD_QUERY) |=> (state_ff != S_IDLE))
      else $error("query accepted but not started");
`endif

endmodule

// ===== verif/tb_gravity_accel_sum_core.sv =====
// tb_gravity_accel_sum_core: self-checking testbench for gravity_accel_sum_core.
// Drives body writes and queries on the req stream, predicts each query result in Q16.16
// and checks the rsp stream against it. Depends on gas_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_gravity_accel_sum_core
   import gas_pkg::*;
;

   localparam int NUM_BODIES = 64;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic        cmd;
      logic [5:0]  idx;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] mass;
   } body_txn_type;

   typedef struct packed {
      logic [31:0] rate_x;
      logic [31:0] rate_y;
      logic [31:0] accel_x;
      logic [31:0] accel_y;
      logic        sat;
   } deriv_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic         csr_addr = 1'b0;
   logic [15:0]  csr_wdata = '0;

   gravity_accel_sum_core #(.MAX_BODIES(NUM_BODIES)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scoreboard-side copy of the body table and registers
   logic [31:0] tbl_x    [NUM_BODIES];
   logic [31:0] tbl_y    [NUM_BODIES];
   logic [31:0] tbl_mass [NUM_BODIES];
   bit          tbl_written [NUM_BODIES];
   logic [6:0]  cfg_count = 7'd0;
   logic [15:0] cfg_min   = 16'd40;

   body_txn_type pending_txns[$];
   deriv_type    expected_derivs[$];
   body_txn_type req_cur;
   bit           req_fire = 0;
   bit           no_idle = 0;
   int           req_gap = 0;
   int           rsp_stall = 0;
   int           mismatches = 0;

   // floor(sqrt(s)) for the 65-bit squared distance
   function automatic logic [127:0] isqrt_wide(input logic [127:0] s);
      logic [127:0] root;
      logic [127:0] cand;
      root = '0;
      for (int k = 33; k >= 0; k--) begin
         cand = root | (128'd1 << k);
         if (cand * cand <= s) root = cand;
      end
      return root;
   endfunction

   function automatic deriv_type compute_deriv(input body_txn_type q);
      deriv_type    d;
      longint       ax, ay, qx, qy, bx, by, dx, dy, cx, cy;
      logic [127:0] mx, my, s, cut2, r, t, g, ux, uy;
      int           n;
      bit           sat;
      ax = 0; ay = 0; sat = 0;
      qx = longint'($signed(q.px));
      qy = longint'($signed(q.py));
      n = (cfg_count > NUM_BODIES) ? NUM_BODIES : int'(cfg_count);
      cut2 = (128'(cfg_min) << 16) * (128'(cfg_min) << 16);
      for (int i = 0; i < n; i++) begin
         bx = longint'($signed(tbl_x[i]));
         by = longint'($signed(tbl_y[i]));
         if (bx == qx) continue;          // same x: body skipped
         dx = qx - bx;
         dy = qy - by;
         mx = 128'(dx < 0 ? -dx : dx);
         my = 128'(dy < 0 ? -dy : dy);
         s = mx * mx + my * my;
         if (s <= cut2) continue;         // inside the cutoff
         r = isqrt_wide(s);
         if (r == 0) continue;
         t = (128'(tbl_mass[i]) << 16) / r;
         g = (t << 16) / r;
         if (g > 128'(G_CAP)) begin
            g = 128'(G_CAP);
            sat = 1;
         end
         ux = (mx << 30) / r;
         uy = (my << 30) / r;
         cx = longint'((g * ux) >> 30);
         cy = longint'((g * uy) >> 30);
         if (dx < 0) ax += cx; else ax -= cx;
         if (dy < 0) ay += cy; else ay -= cy;
      end
      if (ax > 64'sd2147483647) begin ax = 64'sd2147483647; sat = 1; end
      if (ax < -64'sd2147483648) begin ax = -64'sd2147483648; sat = 1; end
      if (ay > 64'sd2147483647) begin ay = 64'sd2147483647; sat = 1; end
      if (ay < -64'sd2147483648) begin ay = -64'sd2147483648; sat = 1; end
      d.rate_x = q.vx;
      d.rate_y = q.vy;
      d.accel_x = ax[31:0];
      d.accel_y = ay[31:0];
      d.sat = sat;
      return d;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // check rsp, then predict from the accepted req transaction
   always @(posedge clock) begin
      deriv_type got, want;
      req_fire <= req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rate_x  = rsp_tdata[31:0];
         got.rate_y  = rsp_tdata[63:32];
         got.accel_x = rsp_tdata[95:64];
         got.accel_y = rsp_tdata[127:96];
         got.sat     = rsp_tuser;
         if (expected_derivs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("rsp transaction with nothing expected");
         end else begin
            want = expected_derivs.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp rx=%h ry=%h ax=%h ay=%h sat=%b,",
                            " got rx=%h ry=%h ax=%h ay=%h sat=%b"},
                           want.rate_x, want.rate_y, want.accel_x, want.accel_y, want.sat,
                           got.rate_x, got.rate_y, got.accel_x, got.accel_y, got.sat);
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         if (req_cur.cmd == CMD_WRITE) begin
            tbl_x[req_cur.idx]    = req_cur.px;
            tbl_y[req_cur.idx]    = req_cur.py;
            tbl_mass[req_cur.idx] = req_cur.mass;
            tbl_written[req_cur.idx] = 1;
         end else begin
            expected_derivs = {expected_derivs, compute_deriv(req_cur)};
         end
      end
   end

   // req driver: one pending transaction at a time, random gaps between unless no_idle is set
   always @(negedge clock) begin
      body_txn_type nxt;
      logic         v;
      if (!reset && (!req_tvalid || req_fire)) begin
         v = 1'b0;
         if (req_gap > 0 && !no_idle) begin
            req_gap <= req_gap - 1;
         end else if (pending_txns.size() > 0) begin
            nxt = pending_txns.pop_front();
            v = 1'b1;
            req_cur <= nxt;
            req_tdata <= {2'b00, nxt.mass, nxt.vy, nxt.vx, nxt.py, nxt.px, nxt.idx};
            req_tuser <= nxt.cmd;
            req_gap <= gap_len();
         end
         req_tvalid <= v;
      end
   end

   // rsp side backpressure
   always @(negedge clock) begin
      if (!reset) begin
         if (no_idle) begin
            rsp_tready <= 1'b1;
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall <= gap_len();
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($urandom_range(0, 32'd131072000)) - 32'd65536000;
   endfunction

   function automatic logic [31:0] rand_mass();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h000F_FFFF);
         default: return $urandom_range(0, 32'h0FFF_FFFF);
      endcase
   endfunction

   function automatic int written_prefix();
      int k;
      k = 0;
      while (k < NUM_BODIES && tbl_written[k]) k++;
      return k;
   endfunction

   task automatic push_write(input int idx, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] m);
      body_txn_type b;
      b.cmd = CMD_WRITE; b.idx = idx[5:0]; b.px = x; b.py = y;
      b.vx = $urandom; b.vy = $urandom; b.mass = m;
      pending_txns = {pending_txns, b};
   endtask

   task automatic push_query(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] vx, input logic [31:0] vy);
      body_txn_type b;
      b.cmd = CMD_QUERY; b.idx = 6'($urandom); b.px = x; b.py = y;
      b.vx = vx; b.vy = vy; b.mass = $urandom;
      pending_txns = {pending_txns, b};
   endtask

   // sender holds off until every expected result is back, then lets the core settle
   task automatic drain();
      while (pending_txns.size() > 0 || req_tvalid || expected_derivs.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic addr, input logic [15:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      if (addr == CSR_BODY_COUNT) cfg_count = data[6:0];
      else cfg_min = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // query point: near a stored body, on its x, or anywhere
   task automatic push_rand_query(input int nb);
      int          k;
      logic [31:0] x, y;
      k = (nb > 0) ? $urandom_range(0, nb - 1) : 0;
      case ($urandom_range(0, 5))
         0: begin x = tbl_x[k]; y = rand_coord(); end
         1: begin
            x = tbl_x[k] + 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
            y = tbl_y[k] + 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
         end
         2: begin x = $urandom; y = $urandom; end
         default: begin x = rand_coord(); y = rand_coord(); end
      endcase
      if (nb == 0) begin x = rand_coord(); y = rand_coord(); end
      push_query(x, y, $urandom, $urandom);
   endtask

   initial begin
      int nb, want, n_items;
      for (int i = 0; i < NUM_BODIES; i++) tbl_written[i] = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, same x, cutoff, saturation
      csr_write(CSR_MIN_DIST, 16'd40);
      csr_write(CSR_BODY_COUNT, 16'd4);
      push_write(0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      push_write(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
      push_write(2, 32'h8000_0000, 32'h8000_0000, 32'h1);
      push_write(63, 32'h0064_0000, 32'hFF9C_0000, 32'h0001_0000);
      push_write(3, 32'h0100_0000, 32'h0, 32'h8000_0000);
      push_query(32'h0, 32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      push_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      push_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      push_query(32'h0001_0000, 32'h0001_0000, 32'h1234_5678, 32'h0);
      push_query(32'h0100_8000, 32'h0000_8000, 32'h1, 32'h2);
      push_query(32'h0500_0000, 32'hFB00_0000, 32'hFFFF_FFFF, 32'h0);
      drain();
      csr_write(CSR_MIN_DIST, 16'd0);
      push_query(32'h0000_0001, 32'h0, 32'h5, 32'h6);
      push_query(32'h0100_0001, 32'h0, 32'h7, 32'h8);
      push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h9, 32'hA);
      drain();
      csr_write(CSR_MIN_DIST, 16'hFFFF);
      push_query(32'h0000_0001, 32'h0, 32'hB, 32'hC);
      push_query(32'h7FFF_FFFF, 32'h8000_0000, 32'hD, 32'hE);
      drain();
      csr_write(CSR_BODY_COUNT, 16'd0);
      push_query(32'h1, 32'h1, 32'hF, 32'h10);
      drain();

      // random phases, small body counts to keep queries short
      for (int p = 0; p < 20; p++) begin
         case ($urandom_range(0, 4))
            0: csr_write(CSR_MIN_DIST, 16'd0);
            1: csr_write(CSR_MIN_DIST, 16'hFFFF);
            2: csr_write(CSR_MIN_DIST, 16'($urandom));
            default: csr_write(CSR_MIN_DIST, 16'($urandom_range(0, 200)));
         endcase
         nb = written_prefix();
         want = $urandom_range(0, 5);
         if (want > nb) want = nb;
         csr_write(CSR_BODY_COUNT, 16'(want));
         no_idle = ($urandom_range(0, 4) == 0);
         n_items = 90;
         for (int j = 0; j < n_items; j++) begin
            if ($urandom_range(0, 99) < 65) begin
               if ($urandom_range(0, 9) == 0) nb = $urandom_range(0, 63);
               else nb = $urandom_range(0, 7);
               // keep the counted entries untouched
               if (nb < want) nb = want + $urandom_range(0, 7);
               push_write(nb, rand_coord(), rand_coord(), rand_mass());
            end else begin
               push_rand_query(want);
            end
         end
         drain();
         no_idle = 0;
      end

      // whole table, then a count past the table size
      csr_write(CSR_BODY_COUNT, 16'd0);
      for (int i = 0; i < NUM_BODIES; i++) push_write(i, rand_coord(), rand_coord(), rand_mass());
      drain();
      csr_write(CSR_MIN_DIST, 16'd0);
      csr_write(CSR_BODY_COUNT, 16'd64);
      for (int j = 0; j < 4; j++) push_rand_query(NUM_BODIES);
      drain();
      csr_write(CSR_BODY_COUNT, 16'd127);
      for (int j = 0; j < 2; j++) push_rand_query(NUM_BODIES);
      drain();

      if (mismatches == 0 && expected_derivs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/gas_pkg.sv
rtl/gas_div.sv
rtl/gas_sqrt.sv
rtl/gas_dp.sv
rtl/gas_ctrl.sv
rtl/gravity_accel_sum_core.sv
verif/tb_gravity_accel_sum_core.sv
